// ----- sv/infix_to_postfix_converter_top_defines.svh -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_defines.svh
// Assertion macros shared by the checker of the infix-to-postfix converter.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ITP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and helper functions of the infix-to-postfix block.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       expr_done;
        logic       last_of_run;
    } t_out_item;

    // Kind of the request currently being worked on.
    typedef enum logic [2:0] {
        CLS_ALNUM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER,
        CLS_END
    } t_cls;

    // Source of an emitted character.
    typedef enum logic [1:0] {
        SRC_SYM,
        SRC_TOP,
        SRC_TERM
    } t_src;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic emit;
        t_src src;
        logic last;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic empty;
        logic full;
        logic top_open;
        logic top_ge;
        logic below_stop;
        logic below_lt;
        logic out_free;
    } t_status;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            CH_CARET:                  p = 2'd3;
            CH_STAR, CH_SLASH, CH_PCT: p = 2'd2;
            CH_PLUS, CH_MINUS:         p = 2'd1;
            default:                   p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

`default_nettype wire

// ----- sv/itp_ctrl.sv -----
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer: takes one request, then steps the stack one move per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire itp_pkg::t_status i_status,
    output itp_pkg::t_cmd         o_cmd
);
    import itp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WORK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.src  = SRC_SYM;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WORK;
                end
            end
            ST_WORK: begin
                case (i_status.cls)
                    CLS_END: begin
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            if (!i_status.empty) begin
                                o_cmd.pop = 1'b1;
                                o_cmd.src = SRC_TOP;
                            end else begin
                                o_cmd.src  = SRC_TERM;
                                o_cmd.last = 1'b1;
                                n_state    = ST_IDLE;
                            end
                        end
                    end
                    CLS_ALNUM: begin
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end
                    CLS_OPEN: begin
                        o_cmd.push = 1'b1;
                        n_state    = ST_IDLE;
                    end
                    CLS_CLOSE: begin
                        if (i_status.empty) begin
                            n_state = ST_IDLE;
                        end else if (i_status.top_open) begin
                            // Discard the matching open parenthesis.
                            o_cmd.pop = 1'b1;
                            n_state   = ST_IDLE;
                        end else if (i_status.out_free) begin
                            o_cmd.pop  = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = SRC_TOP;
                            o_cmd.last = i_status.below_stop;
                        end
                    end
                    CLS_OPER: begin
                        if (!i_status.empty && i_status.top_ge) begin
                            if (i_status.out_free) begin
                                o_cmd.pop  = 1'b1;
                                o_cmd.emit = 1'b1;
                                o_cmd.src  = SRC_TOP;
                                o_cmd.last = i_status.below_lt;
                            end
                        end else begin
                            o_cmd.push = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/itp_dp.sv -----
// ----------------------------------------------------------------------------
// itp_dp
// Datapath: request register, operator stack and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_dp #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire itp_pkg::t_in_item  i_in_data,
    input  wire itp_pkg::t_cmd      i_cmd,
    input  wire logic               i_out_stall,
    output itp_pkg::t_status        o_status,
    output logic                    o_out_valid,
    output itp_pkg::t_out_item      o_out_data
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // The top entry lives in r_top; the one under it is kept in r_below so a
    // pop can proceed every cycle. The memory holds every entry below the top.
    logic [7:0]    mem [STACK_DEPTH];
    logic [7:0]    r_sym;
    logic          r_end;
    logic [7:0]    r_top;
    logic [7:0]    r_below;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_ovalid;
    t_out_item     r_odata;
    t_out_item     n_odata;

    logic [CW-1:0] wr_ptr;
    logic [CW-1:0] rd_ptr;
    logic          empty;
    logic          full;
    logic          cnt_one;
    logic          do_push;
    logic [1:0]    sym_prec;
    t_cls          cls;

    assign empty    = (r_cnt == '0);
    assign full     = (r_cnt == CW'(STACK_DEPTH));
    assign cnt_one  = (r_cnt == CW'(1));
    assign do_push  = i_cmd.push && !full;
    assign wr_ptr   = r_cnt - CW'(1);
    assign rd_ptr   = r_cnt - CW'(3);
    assign sym_prec = prec_of(r_sym);

    always_comb begin
        if (r_end) begin
            cls = CLS_END;
        end else if (is_alnum(r_sym)) begin
            cls = CLS_ALNUM;
        end else if (r_sym == CH_OPEN) begin
            cls = CLS_OPEN;
        end else if (r_sym == CH_CLOSE) begin
            cls = CLS_CLOSE;
        end else begin
            cls = CLS_OPER;
        end
    end

    always_comb begin
        o_status.cls        = cls;
        o_status.empty      = empty;
        o_status.full       = full;
        o_status.top_open   = (r_top == CH_OPEN);
        o_status.top_ge     = (prec_of(r_top) >= sym_prec);
        o_status.below_stop = cnt_one || (r_below == CH_OPEN);
        o_status.below_lt   = cnt_one || (prec_of(r_below) < sym_prec);
        o_status.out_free   = !r_ovalid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym <= i_in_data.symbol;
            r_end <= i_in_data.end_of_expr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push && !empty) begin
            mem[wr_ptr[AW-1:0]] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_top   <= r_sym;
            r_below <= r_top;
        end else if (i_cmd.pop) begin
            r_top   <= r_below;
            r_below <= mem[rd_ptr[AW-1:0]];
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (do_push) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.pop && !empty) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        case (i_cmd.src)
            SRC_SYM:  n_odata = '{out_symbol: r_sym, expr_done: 1'b0,
                                  last_of_run: i_cmd.last};
            SRC_TOP:  n_odata = '{out_symbol: r_top, expr_done: 1'b0,
                                  last_of_run: i_cmd.last};
            SRC_TERM: n_odata = '{out_symbol: CH_NUL, expr_done: 1'b1,
                                  last_of_run: 1'b1};
            default:  n_odata = '{out_symbol: CH_NUL, expr_done: 1'b0,
                                  last_of_run: 1'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= n_odata;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

`default_nettype wire

// ----- sv/infix_to_postfix_converter_top.sv -----
// ----------------------------------------------------------------------------
// Usage:
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one request per
// character of an infix expression, or an end request with end_of_expr set.
// Output channel (o_out_valid / i_out_stall / o_out_data) delivers the
// postfix characters; last_of_run marks the final result caused by one
// request, and expr_done marks the terminator that closes an expression.
// A request is registered at the take and worked on from the next cycle,
// so a letter or digit passes the request register before it reaches the
// output register. The stack moves one entry per cycle unless a move that
// emits waits on a stalled output. The input stays stalled while a request
// is worked on, so a new request is taken only once the last is through.
// Results pass through a single output register; while the receiver stalls,
// the register holds its payload and the sequencer waits before emitting.
// A synchronous active-low reset empties the stack and drops any result.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard infix-to-postfix converter with an operator stack.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire itp_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output itp_pkg::t_out_item      o_out_data
);
    import itp_pkg::*;

    // Commands flow from the sequencer to the datapath; the datapath returns
    // the classification of the current request and the state of its stack.
    t_cmd    cmd;
    t_status status;

    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    itp_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- sv/itp_checker.sv -----
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks of the infix-to-postfix converter, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "infix_to_postfix_converter_top_defines.svh"

module itp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire itp_pkg::t_out_item o_out_data
);
    import itp_pkg::*;

    // A stalled result stays presented and unchanged.
    `ITP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                     o_out_valid && $stable(o_out_data), "result changed while stalled")

    // The terminator is always the last result and carries a zero character.
    `ITP_ASSERT_NOW(a_term_form, o_out_valid && o_out_data.expr_done,
                    o_out_data.last_of_run && (o_out_data.out_symbol == CH_NUL),
                    "malformed terminator")

    // A request is worked on alone: the input stalls right after a take.
    `ITP_ASSERT_NEXT(a_busy_after_take, i_in_valid && !o_in_stall, o_in_stall,
                     "input not stalled after a take")

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (.*);

`default_nettype wire
